@@ src/swdz_pkg.sv @@
// Package for the servo wheel dead-zone filter.
// Holds the shared constants, codes and the per-wheel state record.
// No dependencies.
package swdz_pkg;

   // Number of wheels with their own filter state.
   localparam int WHEELS = 2;
   localparam int WheelIdxW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

   // Top of the raw position range; the dead zone starts at either end.
   localparam logic [9:0] POS_TOP = 10'd1023;
   // Raw velocity readings above this value mean the positive sense.
   localparam logic [10:0] RAW_SPEED_OFFSET = 11'd1023;

   // Command sign codes (two-bit signed field).
   localparam logic [1:0] DIR_ZERO = 2'b00;
   localparam logic [1:0] DIR_POS  = 2'b01;

   // Configuration register indexes.
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 16;
   localparam logic [CsrIndexW-1:0] CSR_MIRROR_MASK    = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_VELOCITY_LIMIT = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_DEAD_ZONE_SPAN = 2'd2;

   // Configuration reset values.
   localparam logic [1:0]  MIRROR_MASK_RESET    = 2'd2;
   localparam logic [9:0]  VELOCITY_LIMIT_RESET = 10'd650;
   localparam logic [15:0] DEAD_ZONE_SPAN_RESET = 16'd55905;

   // Everything the filter remembers about one wheel.
   typedef struct packed {
      logic [9:0]         prev_pos;
      logic               tracking;
      logic signed [10:0] good_speed;
      logic [47:0]        angle;
   } wheel_state_type;

   localparam wheel_state_type WHEEL_STATE_RESET = '{
      prev_pos:   10'd0,
      tracking:   1'b1,
      good_speed: 11'sd0,
      angle:      48'd0
   };

endpackage

@@ src/swdz_state.sv @@
// Per-wheel state bank of the servo wheel dead-zone filter.
// One flop record per wheel, one read port and one write port.
// Depends on swdz_pkg.
module swdz_state
   import swdz_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WheelIdxW-1:0] rd_idx,
   output wheel_state_type      rd_state,
   input  logic                 wr_en,
   input  logic [WheelIdxW-1:0] wr_idx,
   input  wheel_state_type      wr_state
);

   wheel_state_type state_ff [WHEELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WHEELS; w++) begin
            state_ff[w] <= WHEEL_STATE_RESET;
         end
      end else if (wr_en) begin
         state_ff[wr_idx] <= wr_state;
      end
   end

   assign rd_state = state_ff[rd_idx];

endmodule

@@ src/swdz_core.sv @@
// Single-step filter logic of the servo wheel dead-zone filter.
// Combinational: takes one wheel's state and readings, gives its next state.
// Depends on swdz_pkg.
module swdz_core
   import swdz_pkg::*;
(
   input  wheel_state_type    state_cur,
   input  logic [1:0]         direction,
   input  logic [10:0]        raw_speed,
   input  logic [9:0]         raw_position,
   input  logic               mirrored,
   input  logic [9:0]         velocity_limit,
   input  logic [15:0]        dead_zone_span,
   output wheel_state_type    state_next,
   output logic signed [10:0] wheel_speed
);

   logic               pos_cmd;
   logic               entering;
   logic               leaving;
   logic               plausible;
   logic signed [11:0] raw_s;
   logic signed [11:0] speed_u;
   logic signed [11:0] speed_m;
   logic signed [11:0] limit_s;
   logic signed [10:0] pos_diff;
   logic signed [19:0] step_fwd;
   logic signed [19:0] step;
   logic signed [16:0] span_s;
   logic signed [16:0] span_term;
   logic signed [20:0] exit_delta;

   always_comb begin
      pos_cmd = (direction == DIR_POS);

      // Speed in the unmirrored convention: raw above the offset is positive.
      raw_s = $signed({1'b0, raw_speed});
      if (raw_speed > RAW_SPEED_OFFSET) begin
         speed_u = raw_s - $signed({1'b0, RAW_SPEED_OFFSET});
      end else begin
         speed_u = -raw_s;
      end
      speed_m = mirrored ? -speed_u : speed_u;

      limit_s = $signed({2'b00, velocity_limit});
      if (pos_cmd) begin
         plausible = (speed_u >= -limit_s) && (speed_u <= 12'sd0);
      end else begin
         plausible = (speed_u >= 12'sd0) && (speed_u <= limit_s);
      end

      // Angle step in 1/256 counts, negated for a mirrored wheel.
      pos_diff = $signed({1'b0, state_cur.prev_pos}) - $signed({1'b0, raw_position});
      step_fwd = {pos_diff[10], pos_diff, 8'd0};
      step     = mirrored ? -step_fwd : step_fwd;

      span_s     = $signed({1'b0, dead_zone_span});
      span_term  = (pos_cmd ^ mirrored) ? -span_s : span_s;
      exit_delta = {{4{span_term[16]}}, span_term} + {step[19], step};

      if (pos_cmd) begin
         entering = (raw_position == POS_TOP);
         leaving  = (state_cur.prev_pos == 10'd0) && (raw_position != 10'd0);
      end else begin
         entering = (raw_position == 10'd0);
         leaving  = (state_cur.prev_pos == POS_TOP) && (raw_position != POS_TOP);
      end

      state_next          = state_cur;
      state_next.prev_pos = raw_position;
      wheel_speed         = '0;

      if (direction != DIR_ZERO) begin
         priority if (entering && state_cur.tracking) begin
            state_next.tracking = 1'b0;
            wheel_speed         = state_cur.good_speed;
         end else if (!state_cur.tracking) begin
            wheel_speed = state_cur.good_speed;
            if (leaving) begin
               state_next.angle    = state_cur.angle + {{27{exit_delta[20]}}, exit_delta};
               state_next.tracking = 1'b1;
            end
         end else begin
            if (plausible) begin
               wheel_speed           = speed_m[10:0];
               state_next.good_speed = speed_m[10:0];
            end else begin
               wheel_speed = state_cur.good_speed;
            end
            state_next.angle = state_cur.angle + {{28{step[19]}}, step};
         end
      end
   end

endmodule

@@ src/servo_wheel_deadzone_filter.sv @@
// Top level of the servo wheel dead-zone filter.
// Holds the input and result registers, configuration registers and assertions.
// Depends on swdz_pkg, swdz_state and swdz_core.

// Each transaction on the req_ channel carries one wheel's command sign and raw
// servo velocity and position readings; each yields exactly one rsp_ transaction
// with the filtered speed, the accumulated angle and the blind flag for that
// wheel. An accepted transaction sits in an input register until the result
// register can take it, is worked through the filter logic against that wheel's
// state, and lands in the result register, which raises rsp_valid and holds the
// result until rsp_ready takes it.
// One transaction per cycle is taken in steady state; the only limit is the
// result register, which frees up when rsp_ready is high. While a finished
// result waits, the input register can still take one more transaction, after
// which req_ready stays low until the result is taken. Wheel state is
// updated in the same cycle the result is produced, so consecutive
// transactions for the same wheel see each other's effect with no gap.
// Configuration registers are written through csr_write_enable, csr_index and
// csr_write_data; write them only while no transaction is in flight. Writes to
// an unused index are ignored.
module servo_wheel_deadzone_filter
   import swdz_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_wheel,
   input  logic signed [1:0]    req_direction,
   input  logic [10:0]          req_raw_speed,
   input  logic [9:0]           req_raw_position,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [10:0]   rsp_wheel_speed,
   output logic signed [47:0]   rsp_wheel_angle,
   output logic                 rsp_blind,

   input  logic                 csr_write_enable,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_write_data
);

   // Configuration registers.
   logic [1:0]  mirror_mask_ff;
   logic [9:0]  velocity_limit_ff;
   logic [15:0] dead_zone_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_mask_ff    <= MIRROR_MASK_RESET;
         velocity_limit_ff <= VELOCITY_LIMIT_RESET;
         dead_zone_span_ff <= DEAD_ZONE_SPAN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIRROR_MASK:    mirror_mask_ff    <= csr_write_data[1:0];
            CSR_VELOCITY_LIMIT: velocity_limit_ff <= csr_write_data[9:0];
            CSR_DEAD_ZONE_SPAN: dead_zone_span_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic        in_wheel_ff;
   logic [1:0]  in_direction_ff;
   logic [10:0] in_raw_speed_ff;
   logic [9:0]  in_raw_position_ff;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [10:0] rsp_speed_ff;
   logic [47:0]        rsp_angle_ff;
   logic               rsp_blind_ff;

   logic advance;
   logic fire;

   // The result register can take a new value when it is empty or being drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_wheel_ff        <= req_wheel;
         in_direction_ff    <= req_direction;
         in_raw_speed_ff    <= req_raw_speed;
         in_raw_position_ff <= req_raw_position;
      end
   end

   // Wheel selection; indexes beyond the wheel count fold back onto wheel zero.
   logic                 wheel_eff;
   logic [WheelIdxW-1:0] wheel_idx;
   logic                 mirrored;

   assign wheel_eff = (WHEELS > 1) ? in_wheel_ff : 1'b0;
   assign wheel_idx = WheelIdxW'(wheel_eff);
   assign mirrored  = mirror_mask_ff[wheel_eff];

   wheel_state_type    state_cur;
   wheel_state_type    state_next;
   logic signed [10:0] speed_next;

   swdz_state u_state (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (wheel_idx),
      .rd_state (state_cur),
      .wr_en    (fire),
      .wr_idx   (wheel_idx),
      .wr_state (state_next)
   );

   swdz_core u_core (
      .state_cur      (state_cur),
      .direction      (in_direction_ff),
      .raw_speed      (in_raw_speed_ff),
      .raw_position   (in_raw_position_ff),
      .mirrored       (mirrored),
      .velocity_limit (velocity_limit_ff),
      .dead_zone_span (dead_zone_span_ff),
      .state_next     (state_next),
      .wheel_speed    (speed_next)
   );

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_speed_ff <= speed_next;
         rsp_angle_ff <= state_next.angle;
         rsp_blind_ff <= !state_next.tracking;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wheel_speed = rsp_speed_ff;
   assign rsp_wheel_angle = $signed(rsp_angle_ff);
   assign rsp_blind       = rsp_blind_ff;

   // A transaction leaving the input register always shows up as a result.
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed transaction did not reach the result register");

   // With both registers full and the output stalled, no new transaction enters.
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted while the pipeline was full");

   // The filtered speed never takes the out-of-window raw value.
   a_speed_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wheel_speed != 11'h400))
      else $error("filtered speed out of range");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for servo_wheel_deadzone_filter: directed table, then random sweeps.
// Depends on swdz_pkg and the RTL of servo_wheel_deadzone_filter.
module tb
   import swdz_pkg::*;
();

   // Negative command patterns; the two-bit field has two of them.
   localparam logic [1:0] DIR_NEG     = 2'b11;
   localparam logic [1:0] DIR_NEG_ALT = 2'b10;
   // An index that maps to no register; writes there must change nothing.
   localparam logic [CsrIndexW-1:0] CSR_UNUSED = 2'd3;

   localparam int PHASES        = 5;
   localparam int PHASE_READS   = 250;
   localparam int DRAIN_CYCLES  = 4;
   localparam int HOLD_OFF_LONG = 300;

   // One servo reading as it travels on the req_ channel.
   typedef struct packed {
      logic       wheel;
      logic [1:0] direction;
      logic [10:0] raw_speed;
      logic [9:0] raw_position;
   } servo_reading_type;

   // One filtered report as it comes back on the rsp_ channel.
   typedef struct packed {
      logic signed [10:0] speed;
      logic signed [47:0] angle;
      logic               blind;
   } wheel_report_type;

   // A row of the directed table. Where typed is set, the report is written in by hand.
   typedef struct packed {
      logic               wheel;
      logic [1:0]         direction;
      logic [10:0]        raw_speed;
      logic [9:0]         raw_position;
      logic               typed;
      logic signed [10:0] want_speed;
      logic signed [47:0] want_angle;
      logic               want_blind;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 25;

   // The table starts from the reset configuration: wheel 0 plain, wheel 1 mirrored,
   // speed limit 650. It walks wheel 0 into and out of the dead zone in both senses,
   // probes the edges of the speed window, then does the same for the mirrored wheel.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Zero command right after reset: all outputs are still at their reset values.
      '{1'b0, DIR_ZERO,    11'd2047, 10'd1023, 1'b1, 11'sd0, 48'sd0, 1'b0},
      // Position at the top with a positive command: the wheel goes blind at once.
      '{1'b0, DIR_POS,     11'd0,    10'd1023, 1'b1, 11'sd0, 48'sd0, 1'b1},
      // A zero command keeps the blind state.
      '{1'b0, DIR_ZERO,    11'd1500, 10'd512,  1'b1, 11'sd0, 48'sd0, 1'b1},
      '{1'b0, DIR_POS,     11'd400,  10'd1023, 1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b0, DIR_POS,     11'd400,  10'd0,    1'b0, 11'sd0, 48'sd0, 1'b0},
      // Still at zero: the exit needs a position above zero.
      '{1'b0, DIR_POS,     11'd400,  10'd0,    1'b0, 11'sd0, 48'sd0, 1'b0},
      // Leaves the zone, the span is taken off the angle.
      '{1'b0, DIR_POS,     11'd400,  10'd4,    1'b0, 11'sd0, 48'sd0, 1'b0},
      // Exactly at the limit, then one past it, then the wrong sign.
      '{1'b0, DIR_POS,     11'd650,  10'd20,   1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b0, DIR_POS,     11'd651,  10'd40,   1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b0, DIR_POS,     11'd1024, 10'd60,   1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b0, DIR_NEG,     11'd1673, 10'd50,   1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b0, DIR_NEG,     11'd1674, 10'd30,   1'b0, 11'sd0, 48'sd0, 1'b0},
      // Negative command enters the zone at position zero and leaves below the top.
      '{1'b0, DIR_NEG,     11'd0,    10'd0,    1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b0, DIR_NEG,     11'd0,    10'd700,  1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b0, DIR_NEG,     11'd0,    10'd1023, 1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b0, DIR_NEG_ALT, 11'd1100, 10'd1000, 1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b0, DIR_NEG_ALT, 11'd1100, 10'd990,  1'b0, 11'sd0, 48'sd0, 1'b0},
      // Raw 1023 reads as the largest negative speed, beyond the limit.
      '{1'b0, DIR_POS,     11'd1023, 10'd1000, 1'b0, 11'sd0, 48'sd0, 1'b0},
      // Mirrored wheel: speed and angle steps change sign.
      '{1'b1, DIR_POS,     11'd300,  10'd1,    1'b0, 11'sd0, 48'sd0, 1'b0},
      // Raw 2047 is never plausible for either command.
      '{1'b1, DIR_POS,     11'd2047, 10'd5,    1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b1, DIR_NEG,     11'd2047, 10'd3,    1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b1, DIR_POS,     11'd10,   10'd1023, 1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b1, DIR_POS,     11'd10,   10'd0,    1'b0, 11'sd0, 48'sd0, 1'b0},
      // Leaves from zero straight to the top: the largest single step.
      '{1'b1, DIR_POS,     11'd10,   10'd1023, 1'b0, 11'sd0, 48'sd0, 1'b0},
      '{1'b1, DIR_ZERO,    11'd0,    10'd0,    1'b0, 11'sd0, 48'sd0, 1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_wheel = 1'b0;
   logic signed [1:0]    req_direction = '0;
   logic [10:0]          req_raw_speed = '0;
   logic [9:0]           req_raw_position = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [10:0]   rsp_wheel_speed;
   logic signed [47:0]   rsp_wheel_angle;
   logic                 rsp_blind;
   logic                 csr_write_enable = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_write_data = '0;

   // The testbench's own copy of the filter configuration and per-wheel state.
   logic [1:0]  mirror_bits = MIRROR_MASK_RESET;
   logic [9:0]  speed_limit = VELOCITY_LIMIT_RESET;
   logic [15:0] blind_span  = DEAD_ZONE_SPAN_RESET;
   logic [9:0]  wheel_prev_pos   [WHEELS];
   logic        wheel_tracking   [WHEELS];
   int          wheel_good_speed [WHEELS];
   logic [47:0] wheel_angle_sum  [WHEELS];

   // Per-wheel state of the random sweep generator.
   int sweep_sign [WHEELS];
   int sweep_pos  [WHEELS];
   int blind_left [WHEELS];

   wheel_report_type expected_reports [$];
   int               mismatch_count  = 0;
   int               hold_off_cycles = 0;
   bit               idle_enable     = 1'b1;

   servo_wheel_deadzone_filter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_wheel        (req_wheel),
      .req_direction    (req_direction),
      .req_raw_speed    (req_raw_speed),
      .req_raw_position (req_raw_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wheel_speed  (rsp_wheel_speed),
      .rsp_wheel_angle  (rsp_wheel_angle),
      .rsp_blind        (rsp_blind),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the report for one accepted reading and advances the wheel state.
   function automatic wheel_report_type filter_reading(input servo_reading_type rd);
      int unsigned      w;
      longint           sgn;
      longint           step_len;
      longint           delta;
      int               u;
      int               speed;
      int               lim;
      logic [9:0]       prev;
      logic [9:0]       enter_at;
      logic             pos_cmd;
      logic             leaving;
      logic             moved;
      logic             plausible;
      wheel_report_type rep;
      w = rd.wheel % WHEELS;
      sgn = mirror_bits[w] ? -1 : 1;
      lim = int'(speed_limit);
      prev = wheel_prev_pos[w];
      step_len = (longint'(prev) - longint'(rd.raw_position)) * 256 * sgn;
      // Bit 10 of the raw reading is the sense; below it the reading is a negative speed.
      u = (rd.raw_speed > RAW_SPEED_OFFSET) ? int'(rd.raw_speed) - int'(RAW_SPEED_OFFSET)
                                             : -int'(rd.raw_speed);
      moved = 1'b0;
      delta = 0;
      if (rd.direction == DIR_ZERO) begin
         speed = 0;
      end else begin
         pos_cmd = (rd.direction == DIR_POS);
         enter_at = pos_cmd ? POS_TOP : 10'd0;
         leaving = pos_cmd ? (prev == 10'd0 && rd.raw_position != 10'd0)
                           : (prev == POS_TOP && rd.raw_position != POS_TOP);
         if (rd.raw_position == enter_at && wheel_tracking[w]) begin
            wheel_tracking[w] = 1'b0;
            speed = wheel_good_speed[w];
         end else if (!wheel_tracking[w]) begin
            speed = wheel_good_speed[w];
            if (leaving) begin
               // The blind arc is credited in the direction of travel.
               delta = longint'(blind_span) * (pos_cmd ? -1 : 1) * sgn + step_len;
               moved = 1'b1;
               wheel_tracking[w] = 1'b1;
            end
         end else begin
            // The window is judged in the plain convention, before any mirroring.
            plausible = pos_cmd ? (u >= -lim && u <= 0) : (u >= 0 && u <= lim);
            if (plausible) begin
               speed = int'(u * sgn);
               wheel_good_speed[w] = speed;
            end else begin
               speed = wheel_good_speed[w];
            end
            delta = step_len;
            moved = 1'b1;
         end
      end
      if (moved) begin
         wheel_angle_sum[w] = wheel_angle_sum[w] + delta[47:0];
      end
      wheel_prev_pos[w] = rd.raw_position;
      rep.speed = speed[10:0];
      rep.angle = wheel_angle_sum[w];
      rep.blind = !wheel_tracking[w];
      return rep;
   endfunction

   // Random readings. Most follow a wheel that turns steadily, hits the end of the
   // range, reads junk through the blind arc and comes out at the far end, so the
   // enter, hold and exit paths are taken over and over. The rest is noise.
   function automatic servo_reading_type next_random_reading();
      servo_reading_type rd;
      int                w;
      int                roll;
      int                stride;
      int                lim;
      w = $urandom_range(0, WHEELS - 1);
      roll = $urandom_range(0, 99);
      lim = int'(speed_limit);
      rd.wheel = w[0];
      rd.direction = 2'($urandom_range(0, 3));
      rd.raw_speed = 11'($urandom_range(0, 2047));
      rd.raw_position = 10'($urandom_range(0, 1023));
      if (roll < 10) begin
         return rd;
      end
      if (roll < 14) begin
         rd.direction = DIR_ZERO;
         return rd;
      end
      if ($urandom_range(0, 49) == 0) begin
         sweep_sign[w] = -sweep_sign[w];
      end
      if (blind_left[w] > 0) begin
         rd.raw_position = 10'($urandom_range(1, 1022));
         blind_left[w]--;
      end else if (blind_left[w] == 0) begin
         // Comes out of the blind arc at the opposite end of the range.
         sweep_pos[w] = (sweep_sign[w] > 0) ? 0 : 1023;
         rd.raw_position = sweep_pos[w][9:0];
         blind_left[w] = -1;
      end else begin
         stride = $urandom_range(1, 60);
         sweep_pos[w] += sweep_sign[w] * stride;
         if (sweep_pos[w] >= 1023 || sweep_pos[w] <= 0) begin
            sweep_pos[w] = (sweep_sign[w] > 0) ? 1023 : 0;
            blind_left[w] = $urandom_range(0, 3);
         end
         rd.raw_position = sweep_pos[w][9:0];
      end
      if (sweep_sign[w] > 0) begin
         rd.direction = DIR_POS;
      end else begin
         rd.direction = ($urandom_range(0, 3) == 0) ? DIR_NEG_ALT : DIR_NEG;
      end
      // Mostly a speed inside the window of the command, sometimes anything at all.
      if ($urandom_range(0, 9) < 8) begin
         if (sweep_sign[w] > 0) begin
            rd.raw_speed = 11'($urandom_range(0, lim));
         end else if (lim == 0 || $urandom_range(0, 9) == 0) begin
            rd.raw_speed = '0;
         end else begin
            rd.raw_speed = 11'(int'(RAW_SPEED_OFFSET) + int'($urandom_range(1, lim)));
         end
      end
      return rd;
   endfunction

   function automatic void log_mismatch(input string field, input longint want,
                                        input longint got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   // Presents one reading, holds it until the DUT takes it, then records the report
   // that transaction must produce. Called right after a rising edge, returns at one.
   task automatic offer(input servo_reading_type rd, input bit typed,
                        input wheel_report_type typed_report);
      wheel_report_type rep;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_wheel        <= rd.wheel;
      req_direction    <= rd.direction;
      req_raw_speed    <= rd.raw_speed;
      req_raw_position <= rd.raw_position;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The wheel state must move on even where the table gives the report by hand.
      rep = filter_reading(rd);
      if (typed) begin
         rep = typed_report;
      end
      expected_reports = {expected_reports, rep};
   endtask

   // Stops offering and waits until every outstanding transaction has reported.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers back to back, then a junk write to the unused index.
   // Upper bits beyond a register's width carry junk and must be dropped.
   task automatic set_config(input logic [15:0] mask_word, input logic [15:0] limit_word,
                             input logic [15:0] span_word);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MIRROR_MASK;
      csr_write_data   <= mask_word;
      @(posedge clock);
      csr_index      <= CSR_VELOCITY_LIMIT;
      csr_write_data <= limit_word;
      @(posedge clock);
      csr_index      <= CSR_DEAD_ZONE_SPAN;
      csr_write_data <= span_word;
      @(posedge clock);
      csr_index      <= CSR_UNUSED;
      csr_write_data <= 16'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mirror_bits = mask_word[1:0];
      speed_limit = limit_word[9:0];
      blind_span  = span_word;
   endtask

   // Main sequence: reset, the directed table under the reset configuration, then
   // five random phases, each under its own configuration. The long receiver hold-off
   // in phase one fills the pipeline and stalls the input; phase two pauses the
   // sender until all results are back; the last phase runs with no idling at all.
   initial begin : stimulus
      directed_row_type  row;
      servo_reading_type rd;
      wheel_report_type  typed_report;
      int                i;
      int                phase;
      int                n;
      for (i = 0; i < WHEELS; i++) begin
         wheel_prev_pos[i]   = '0;
         wheel_tracking[i]   = 1'b1;
         wheel_good_speed[i] = 0;
         wheel_angle_sum[i]  = '0;
         sweep_sign[i]       = (i % 2 == 0) ? 1 : -1;
         sweep_pos[i]        = $urandom_range(0, 1023);
         blind_left[i]       = -1;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         rd.wheel        = row.wheel;
         rd.direction    = row.direction;
         rd.raw_speed    = row.raw_speed;
         rd.raw_position = row.raw_position;
         typed_report.speed = row.want_speed;
         typed_report.angle = row.want_angle;
         typed_report.blind = row.want_blind;
         offer(rd, row.typed, typed_report);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         // Registers change only with nothing in flight.
         settle();
         case (phase)
            0: begin
               set_config(16'hFFFC, 16'h03FF, 16'hFFFF);
            end
            1: begin
               set_config(16'h0003, 16'hFC00, 16'h0000);
            end
            2: begin
               set_config(16'h0001, 16'($urandom_range(1, 1022)), 16'($urandom));
            end
            3: begin
               set_config(16'($urandom), 16'($urandom), 16'($urandom));
            end
            default: begin
               set_config(16'(MIRROR_MASK_RESET), 16'(VELOCITY_LIMIT_RESET),
                          DEAD_ZONE_SPAN_RESET);
               idle_enable = 1'b0;
            end
         endcase
         for (n = 0; n < PHASE_READS; n++) begin
            if (phase == 1 && n == 40) begin
               hold_off_cycles = HOLD_OFF_LONG;
            end
            if (phase == 2 && n == 100) begin
               settle();
            end
            offer(next_random_reading(), 1'b0, '0);
         end
      end

      settle();
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Result side: normally ready, with random stalls, and one long hold-off on request
   // so that the block backs up all the way to its input.
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_ready <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every accepted report is checked against the oldest outstanding expectation.
   always @(posedge clock) begin : result_check
      wheel_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            log_mismatch("report with no transaction outstanding, wheel_speed", 0,
                         longint'(rsp_wheel_speed));
         end else begin
            want = expected_reports.pop_front();
            if (rsp_wheel_speed !== want.speed) begin
               log_mismatch("wheel_speed", longint'(want.speed), longint'(rsp_wheel_speed));
            end
            if (rsp_wheel_angle !== want.angle) begin
               log_mismatch("wheel_angle", longint'(want.angle), longint'(rsp_wheel_angle));
            end
            if (rsp_blind !== want.blind) begin
               log_mismatch("blind", longint'(want.blind), longint'(rsp_blind));
            end
         end
      end
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #(5_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule

@@ filelist.f @@
src/swdz_pkg.sv
src/swdz_state.sv
src/swdz_core.sv
src/servo_wheel_deadzone_filter.sv
tb/tb.sv
